// ===== rtl/edgc_pkg.sv =====
// ----------------------------------------------------------------------------
// edgc_pkg
// Shared widths, register indexes and types for the ellipse density grid
// cell block.
// ----------------------------------------------------------------------------
package edgc_pkg;

    localparam int CELL_W   = 9;
    localparam int NIMG     = 5;
    localparam int NCELL    = NIMG * NIMG;
    localparam int GRID_X_DEF = 512;
    localparam int GRID_Y_DEF = 512;
    localparam longint ONE  = 65536;

    localparam int CRD_W    = 32;
    localparam int DX_W     = 33;
    localparam int ROT_W    = 65;
    localparam int XR_W     = 36;
    localparam int SCL_W    = 68;
    localparam int XS_W     = 19;
    localparam int SQ_W     = 38;
    localparam int R2_W     = 23;
    localparam int U_W      = 23;
    localparam int V_W      = 22;
    localparam int PVP_W    = 44;
    localparam int PV_W     = 26;
    localparam int PP_W     = 49;
    localparam int POLY_W   = 32;
    localparam int WL_W     = 24;
    localparam int WH_W     = 24;
    localparam int LO_W     = 57;
    localparam int HI_W     = 56;
    localparam int FULL_W   = 80;
    localparam int TERM_W   = 64;
    localparam int SUM_W    = 69;
    localparam int DEPTH    = 12;

    localparam int IDX_W    = 3;
    localparam int DATA_W   = 48;
    localparam int INV_W    = 31;
    localparam int WT_W     = 48;

    localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_COS      = 3'd2;
    localparam logic [IDX_W-1:0] REG_SIN      = 3'd3;
    localparam logic [IDX_W-1:0] REG_INV_MAJ  = 3'd4;
    localparam logic [IDX_W-1:0] REG_INV_MIN  = 3'd5;
    localparam logic [IDX_W-1:0] REG_WEIGHT   = 3'd6;

    typedef struct packed {
        logic              vld;
        logic [CELL_W-1:0] x;
        logic [CELL_W-1:0] y;
    } chain_t;

    typedef struct packed {
        logic signed [CRD_W-1:0] center_x;
        logic signed [CRD_W-1:0] center_y;
        logic signed [CRD_W-1:0] cos_angle;
        logic signed [CRD_W-1:0] sin_angle;
        logic [INV_W-1:0]        inv_major;
        logic [INV_W-1:0]        inv_minor;
        logic signed [WT_W-1:0]  weight;
    } cfg_t;

endpackage

// ===== rtl/ellipse_density_grid_cell.sv =====
// ----------------------------------------------------------------------------
// ellipse_density_grid_cell
// Density contribution of one configured ellipse to one grid cell, summed
// over the 25 mirror images of the cell centre.
// ----------------------------------------------------------------------------
// A cell request is taken on every clock (busy stays low) and its result
// appears on density_delta with done high for one cycle. The request moves
// through the chain of 25 image cells, one per mirror image, one cell a
// clock, then through the 12-stage multiply pipeline inside the last cell
// and the output register.
// The result cannot be held off: it is valid only in the cycle that done
// marks. Write the ellipse registers only while no request is in flight.
module ellipse_density_grid_cell #(
    parameter int GRID_X = edgc_pkg::GRID_X_DEF,
    parameter int GRID_Y = edgc_pkg::GRID_Y_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [edgc_pkg::CELL_W-1:0]          cell_x,
    input  logic [edgc_pkg::CELL_W-1:0]          cell_y,
    output logic                                 done,
    output logic signed [edgc_pkg::WT_W-1:0]     density_delta,
    input  logic                                 wr_en,
    input  logic [edgc_pkg::IDX_W-1:0]           wr_index,
    input  logic [edgc_pkg::DATA_W-1:0]          wr_data
);

    localparam int NCELL = edgc_pkg::NCELL;
    localparam int NIMG  = edgc_pkg::NIMG;
    localparam int SUMW  = edgc_pkg::SUM_W;
    localparam int OUTW  = edgc_pkg::WT_W;
    localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((64'sd1 <<< (OUTW - 1)) - 64'sd1);
    localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

    edgc_pkg::cfg_t   cfg_reg;
    edgc_pkg::chain_t chain [0:NCELL];
    logic signed [SUMW-1:0] sums [0:NCELL];
    logic [NCELL-1:0] svld;

    logic                    done_reg;
    logic signed [OUTW-1:0]  dd_reg, dd_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x  <= '0;
            cfg_reg.center_y  <= '0;
            cfg_reg.cos_angle <= 32'sd1073741824;
            cfg_reg.sin_angle <= '0;
            cfg_reg.inv_major <= edgc_pkg::INV_W'(edgc_pkg::ONE);
            cfg_reg.inv_minor <= edgc_pkg::INV_W'(edgc_pkg::ONE);
            cfg_reg.weight    <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                edgc_pkg::REG_CENTER_X: cfg_reg.center_x  <= $signed(wr_data[31:0]);
                edgc_pkg::REG_CENTER_Y: cfg_reg.center_y  <= $signed(wr_data[31:0]);
                edgc_pkg::REG_COS:      cfg_reg.cos_angle <= $signed(wr_data[31:0]);
                edgc_pkg::REG_SIN:      cfg_reg.sin_angle <= $signed(wr_data[31:0]);
                edgc_pkg::REG_INV_MAJ:  cfg_reg.inv_major <= wr_data[edgc_pkg::INV_W-1:0];
                edgc_pkg::REG_INV_MIN:  cfg_reg.inv_minor <= wr_data[edgc_pkg::INV_W-1:0];
                edgc_pkg::REG_WEIGHT:   cfg_reg.weight    <= $signed(wr_data[OUTW-1:0]);
                default:                ;
            endcase
        end
    end

    assign chain[0].vld = start && !busy;
    assign chain[0].x   = cell_x;
    assign chain[0].y   = cell_y;
    assign sums[0]      = '0;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        edgc_cell #(
            .GRID_X (GRID_X),
            .GRID_Y (GRID_Y),
            .IMG_X  (i / NIMG),
            .IMG_Y  (i % NIMG)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (cfg_reg),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .sum_in    (sums[i]),
            .sum_out   (sums[i+1]),
            .sum_vld   (svld[i])
        );
    end

    always_comb
    begin
        if (sums[NCELL] > SAT_HI)
        begin
            dd_next = OUTW'(SAT_HI);
        end
        else if (sums[NCELL] < SAT_LO)
        begin
            dd_next = OUTW'(SAT_LO);
        end
        else
        begin
            dd_next = OUTW'(sums[NCELL]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= svld[NCELL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        dd_reg <= dd_next;
    end

    assign done          = done_reg;
    assign density_delta = dd_reg;

    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##37 done)
        else $error("request not answered after chain latency");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 37))
        else $error("result without matching request");

    a_chain_align: assert property (@(posedge clk) disable iff (!rst_n)
        svld[NCELL-1] |-> svld[0] == $past(chain[0].vld, edgc_pkg::DEPTH + NCELL - 1 - (NCELL - 1) * 1 - 0)
                          || !svld[0])
        else $error("partial sum out of step along the chain");

endmodule

// ===== rtl/edgc_cell.sv =====
// ----------------------------------------------------------------------------
// edgc_cell
// One image evaluator of the chain: forwards the cell request to its
// neighbour, computes the term of its own mirror image and adds it to the
// partial sum arriving from the previous cell.
// ----------------------------------------------------------------------------
module edgc_cell #(
    parameter int GRID_X = edgc_pkg::GRID_X_DEF,
    parameter int GRID_Y = edgc_pkg::GRID_Y_DEF,
    parameter int IMG_X  = 0,
    parameter int IMG_Y  = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  edgc_pkg::cfg_t                    cfg,
    input  edgc_pkg::chain_t                  chain_in,
    output edgc_pkg::chain_t                  chain_out,
    input  logic signed [edgc_pkg::SUM_W-1:0] sum_in,
    output logic signed [edgc_pkg::SUM_W-1:0] sum_out,
    output logic                              sum_vld
);

    localparam int CRDW  = edgc_pkg::CRD_W;
    localparam int DXW   = edgc_pkg::DX_W;
    localparam int ROTW  = edgc_pkg::ROT_W;
    localparam int XRW   = edgc_pkg::XR_W;
    localparam int SCLW  = edgc_pkg::SCL_W;
    localparam int XSW   = edgc_pkg::XS_W;
    localparam int SQW   = edgc_pkg::SQ_W;
    localparam int R2W   = edgc_pkg::R2_W;
    localparam int UW    = edgc_pkg::U_W;
    localparam int VW    = edgc_pkg::V_W;
    localparam int PVPW  = edgc_pkg::PVP_W;
    localparam int PVW   = edgc_pkg::PV_W;
    localparam int PPW   = edgc_pkg::PP_W;
    localparam int POLYW = edgc_pkg::POLY_W;
    localparam int WLW   = edgc_pkg::WL_W;
    localparam int LOW   = edgc_pkg::LO_W;
    localparam int HIW   = edgc_pkg::HI_W;
    localparam int FULLW = edgc_pkg::FULL_W;
    localparam int TERMW = edgc_pkg::TERM_W;
    localparam int SUMW  = edgc_pkg::SUM_W;
    localparam int DEPTH = edgc_pkg::DEPTH;

    localparam int  KX    = IMG_X - 2;
    localparam int  KY    = IMG_Y - 2;
    localparam bit  ODD_X = (KX % 2) != 0;
    localparam bit  ODD_Y = (KY % 2) != 0;
    localparam longint MX = longint'(KX + (ODD_X ? 1 : 0));
    localparam longint MY = longint'(KY + (ODD_Y ? 1 : 0));
    localparam logic signed [CRDW-1:0] BASE_X = CRDW'(MX * GRID_X * edgc_pkg::ONE);
    localparam logic signed [CRDW-1:0] BASE_Y = CRDW'(MY * GRID_Y * edgc_pkg::ONE);
    localparam logic signed [SCLW-1:0] XS_LIM = SCLW'(4 * edgc_pkg::ONE);
    localparam logic signed [R2W-1:0]  R2_LIM = R2W'(16 * edgc_pkg::ONE);
    localparam logic signed [UW-1:0]   U_OFS  = UW'(4 * edgc_pkg::ONE);
    localparam logic signed [VW-1:0]   V_OFS  = VW'(16 * edgc_pkg::ONE);

    edgc_pkg::chain_t fwd_reg;
    logic [DEPTH:1] vld_reg;

    logic signed [CRDW-1:0]  cpx, cpy, px, py;
    logic signed [DXW-1:0]   dx_reg, dy_reg, dx_next, dy_next;
    logic signed [ROTW-1:0]  pxc_reg, pys_reg, pyc_reg, pxs_reg;
    logic signed [XRW-1:0]   xr_reg, yr_reg;
    logic signed [SCLW-1:0]  xm_reg, ym_reg, xm_sh, ym_sh;
    logic signed [XSW-1:0]   xs_reg, ys_reg;
    logic signed [SQW-1:0]   xx_reg, yy_reg;
    logic signed [SQW:0]     sq_sum;
    logic signed [R2W-1:0]   r2;
    logic signed [UW-1:0]    u_reg, u2_reg, negu;
    logic signed [VW-1:0]    v_reg;
    logic signed [PVPW-1:0]  pvp;
    logic signed [PVW-1:0]   pv_reg;
    logic signed [PPW-1:0]   pp_reg;
    logic signed [POLYW-1:0] poly;
    logic signed [LOW-1:0]   lo_reg;
    logic signed [HIW-1:0]   hi_reg;
    logic signed [FULLW-1:0] full;
    logic signed [TERMW-1:0] term_reg;
    logic signed [SUMW-1:0]  sum_reg;
    logic ok5_reg, ok6_reg, ok7_reg, ok8_reg, ok9_reg, ok10_reg;
    logic in_rng;

    always_comb
    begin
        cpx = $signed({{(CRDW-edgc_pkg::CELL_W-16){1'b0}}, chain_in.x, 16'h8000});
        cpy = $signed({{(CRDW-edgc_pkg::CELL_W-16){1'b0}}, chain_in.y, 16'h8000});
        px = ODD_X ? (BASE_X - cpx) : (BASE_X + cpx);
        py = ODD_Y ? (BASE_Y - cpy) : (BASE_Y + cpy);
        dx_next = DXW'(px) - DXW'(cfg.center_x);
        dy_next = DXW'(py) - DXW'(cfg.center_y);
        xm_sh = xm_reg >>> 16;
        ym_sh = ym_reg >>> 16;
        in_rng = (xm_sh < XS_LIM) && (xm_sh > -XS_LIM) && (ym_sh < XS_LIM) && (ym_sh > -XS_LIM);
        sq_sum = (SQW+1)'(xx_reg) + (SQW+1)'(yy_reg);
        r2 = R2W'(sq_sum >>> 16);
        pvp = PVPW'(v_reg) * PVPW'(v_reg);
        negu = -u2_reg;
        poly = POLYW'(pp_reg >>> 16);
        full = (FULLW'(hi_reg) <<< 24) + FULLW'(lo_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= '0;
            vld_reg <= '0;
        end
        else
        begin
            fwd_reg <= chain_in;
            vld_reg <= {vld_reg[DEPTH-1:1], chain_in.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        pxc_reg  <= ROTW'(dx_reg) * ROTW'(cfg.cos_angle);
        pys_reg  <= ROTW'(dy_reg) * ROTW'(cfg.sin_angle);
        pyc_reg  <= ROTW'(dy_reg) * ROTW'(cfg.cos_angle);
        pxs_reg  <= ROTW'(dx_reg) * ROTW'(cfg.sin_angle);
        xr_reg   <= XRW'(pxc_reg >>> 30) + XRW'(pys_reg >>> 30);
        yr_reg   <= XRW'(pyc_reg >>> 30) - XRW'(pxs_reg >>> 30);
        xm_reg   <= SCLW'(xr_reg) * SCLW'($signed({1'b0, cfg.inv_major}));
        ym_reg   <= SCLW'(yr_reg) * SCLW'($signed({1'b0, cfg.inv_minor}));
        xs_reg   <= XSW'(xm_sh);
        ys_reg   <= XSW'(ym_sh);
        ok5_reg  <= in_rng;
        xx_reg   <= SQW'(xs_reg) * SQW'(xs_reg);
        yy_reg   <= SQW'(ys_reg) * SQW'(ys_reg);
        ok6_reg  <= ok5_reg;
        u_reg    <= UW'(r2) - U_OFS;
        v_reg    <= V_OFS - VW'(r2);
        ok7_reg  <= ok6_reg && (r2 < R2_LIM);
        pv_reg   <= PVW'(pvp >>> 16);
        u2_reg   <= u_reg;
        ok8_reg  <= ok7_reg;
        pp_reg   <= PPW'(negu) * PPW'(pv_reg);
        ok9_reg  <= ok8_reg;
        lo_reg   <= LOW'($signed({1'b0, cfg.weight[WLW-1:0]})) * LOW'(poly);
        hi_reg   <= HIW'($signed(cfg.weight[edgc_pkg::WT_W-1:WLW])) * HIW'(poly);
        ok10_reg <= ok9_reg;
        term_reg <= ok10_reg ? TERMW'(full >>> 16) : '0;
        sum_reg  <= sum_in + SUMW'(term_reg);
    end

    assign chain_out = fwd_reg;
    assign sum_out   = sum_reg;
    assign sum_vld   = vld_reg[DEPTH];

endmodule

// ===== tb/ellipse_density_grid_cell_tb.sv =====
// ----------------------------------------------------------------------------
// ellipse_density_grid_cell_tb
// Drives cell requests through the ellipse density block under several
// ellipse settings (default, wide, rotated, extreme and random) and checks
// each density_delta against a bit-exact model of the 25-image sum.
// ----------------------------------------------------------------------------
module ellipse_density_grid_cell_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [edgc_pkg::CELL_W-1:0] x;
        logic [edgc_pkg::CELL_W-1:0] y;
    } cell_req_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [edgc_pkg::IDX_W-1:0] REG_SPARE = 3'd7;

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic [edgc_pkg::CELL_W-1:0]       cell_x;
    logic [edgc_pkg::CELL_W-1:0]       cell_y;
    logic                              done;
    logic signed [edgc_pkg::WT_W-1:0]  density_delta;
    logic                              wr_en;
    logic [edgc_pkg::IDX_W-1:0]        wr_index;
    logic [edgc_pkg::DATA_W-1:0]       wr_data;

    edgc_pkg::cfg_t                    ellipse;
    cell_req_t                         cell_queue[$];
    logic signed [edgc_pkg::WT_W-1:0]  density_queue[$];
    int                                errors;
    int                                burst_left;
    int                                gap_left;
    int                                idle_cycles;

    ellipse_density_grid_cell i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .done          (done),
        .density_delta (density_delta),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic wide_t image_term(wide_t px, wide_t py);
        wide_t dx, dy, c, s, ia, ib, xr, yr, xs, ys, r2, u, v, pv, poly, w;
        c  = ellipse.cos_angle;
        s  = ellipse.sin_angle;
        ia = ellipse.inv_major;
        ib = ellipse.inv_minor;
        w  = ellipse.weight;
        dx = px - wide_t'(ellipse.center_x);
        dy = py - wide_t'(ellipse.center_y);
        xr = ((dx * c) >>> 30) + ((dy * s) >>> 30);
        yr = ((dy * c) >>> 30) - ((dx * s) >>> 30);
        xs = (xr * ia) >>> 16;
        ys = (yr * ib) >>> 16;
        if (xs >= 4 * edgc_pkg::ONE || xs <= -4 * edgc_pkg::ONE ||
            ys >= 4 * edgc_pkg::ONE || ys <= -4 * edgc_pkg::ONE)
            return 0;
        r2 = (xs * xs + ys * ys) >>> 16;
        if (r2 >= 16 * edgc_pkg::ONE)
            return 0;
        u    = r2 - 4 * edgc_pkg::ONE;
        v    = 16 * edgc_pkg::ONE - r2;
        pv   = (v * v) >>> 16;
        poly = (-u * pv) >>> 16;
        return (w * poly) >>> 16;
    endfunction

    function automatic logic signed [edgc_pkg::WT_W-1:0] cell_density(
        logic [edgc_pkg::CELL_W-1:0] x, logic [edgc_pkg::CELL_W-1:0] y);
        wide_t cx, cy, px, py, sum, hi, lo;
        int    mi, mj;
        cx  = x;
        cy  = y;
        cx  = (cx <<< 16) + edgc_pkg::ONE / 2;
        cy  = (cy <<< 16) + edgc_pkg::ONE / 2;
        sum = 0;
        hi  = (wide_t'(1) <<< (edgc_pkg::WT_W - 1)) - 1;
        lo  = -(wide_t'(1) <<< (edgc_pkg::WT_W - 1));
        for (int i = -2; i <= 2; i++)
        begin
            mi = i + ((i % 2 != 0) ? 1 : 0);
            px = wide_t'(mi) * edgc_pkg::GRID_X_DEF * edgc_pkg::ONE + ((i % 2 != 0) ? -cx : cx);
            for (int j = -2; j <= 2; j++)
            begin
                mj  = j + ((j % 2 != 0) ? 1 : 0);
                py  = wide_t'(mj) * edgc_pkg::GRID_Y_DEF * edgc_pkg::ONE
                      + ((j % 2 != 0) ? -cy : cy);
                sum = sum + image_term(px, py);
            end
        end
        if (sum > hi)
            sum = hi;
        if (sum < lo)
            sum = lo;
        return sum[edgc_pkg::WT_W-1:0];
    endfunction

    // driver: bursts of requests with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            cell_x     <= '0;
            cell_y     <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (start && !busy)
                density_queue.push_back(cell_density(cell_x, cell_y));
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end
                else if (cell_queue.size() > 0)
                begin
                    cell_req_t req;
                    req    = cell_queue.pop_front();
                    start  <= 1'b1;
                    cell_x <= req.x;
                    cell_y <= req.y;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(40, 1);
                        gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (density_queue.size() == 0)
            begin
                $error("density_delta: unexpected result %0d", density_delta);
                errors++;
            end
            else
            begin
                logic signed [edgc_pkg::WT_W-1:0] exp_val;
                exp_val = density_queue.pop_front();
                if (density_delta !== exp_val)
                begin
                    $error("density_delta: expected %0d, actual %0d", exp_val, density_delta);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [edgc_pkg::IDX_W-1:0] idx,
                             logic [edgc_pkg::DATA_W-1:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        case (idx)
            edgc_pkg::REG_CENTER_X: ellipse.center_x  = data[edgc_pkg::CRD_W-1:0];
            edgc_pkg::REG_CENTER_Y: ellipse.center_y  = data[edgc_pkg::CRD_W-1:0];
            edgc_pkg::REG_COS:      ellipse.cos_angle = data[edgc_pkg::CRD_W-1:0];
            edgc_pkg::REG_SIN:      ellipse.sin_angle = data[edgc_pkg::CRD_W-1:0];
            edgc_pkg::REG_INV_MAJ:  ellipse.inv_major = data[edgc_pkg::INV_W-1:0];
            edgc_pkg::REG_INV_MIN:  ellipse.inv_minor = data[edgc_pkg::INV_W-1:0];
            edgc_pkg::REG_WEIGHT:   ellipse.weight    = data[edgc_pkg::WT_W-1:0];
            default:                ;
        endcase
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic set_ellipse(logic [31:0] cx, logic [31:0] cy, logic [31:0] c,
                               logic [31:0] s, logic [30:0] ia, logic [30:0] ib,
                               logic [47:0] w);
        write_reg(edgc_pkg::REG_CENTER_X, {16'b0, cx});
        write_reg(edgc_pkg::REG_CENTER_Y, {16'b0, cy});
        write_reg(edgc_pkg::REG_COS, {16'b0, c});
        write_reg(edgc_pkg::REG_SIN, {16'b0, s});
        write_reg(edgc_pkg::REG_INV_MAJ, {17'b0, ia});
        write_reg(edgc_pkg::REG_INV_MIN, {17'b0, ib});
        write_reg(edgc_pkg::REG_WEIGHT, w);
    endtask

    task automatic add_cell(int x, int y);
        cell_queue.push_back('{x: x[edgc_pkg::CELL_W-1:0], y: y[edgc_pkg::CELL_W-1:0]});
    endtask

    task automatic add_random_cells(int n, int cx, int cy, int spread);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(3, 0) == 0)
                add_cell($urandom_range(511, 0), $urandom_range(511, 0));
            else
                add_cell((cx + $urandom_range(2 * spread, 0) - spread) & 511,
                         (cy + $urandom_range(2 * spread, 0) - spread) & 511);
        end
    endtask

    task automatic drain;
        while (cell_queue.size() > 0 || start || density_queue.size() > 0)
            @(posedge clk);
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    initial
    begin
        errors   = 0;
        rst_n    = 1'b0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = '0;
        ellipse  = '{center_x: 0, center_y: 0, cos_angle: 32'sd1073741824,
                     sin_angle: 0, inv_major: 31'd65536, inv_minor: 31'd65536,
                     weight: 0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset values, zero weight
        add_cell(0, 0);
        add_cell(511, 511);
        drain();

        // unit ellipse near the origin; corners hit through mirror images
        write_reg(REG_SPARE, rand48());
        write_reg(edgc_pkg::REG_WEIGHT, 48'h0000_0100_0000);
        add_cell(0, 0);
        add_cell(511, 511);
        add_cell(0, 511);
        add_cell(511, 0);
        add_cell(1, 2);
        add_cell(256, 256);
        drain();

        // wide ellipse
        set_ellipse(32'd10_000_000, 32'd8_000_000, 32'sd1073741824, 32'd0,
                    31'd3277, 31'd1000, 48'h0000_0123_4567);
        add_cell(152, 122);
        add_cell(150, 120);
        add_cell(0, 0);
        add_cell(511, 511);
        add_random_cells(80, 152, 122, 100);
        drain();

        // rotated by 45 degrees
        set_ellipse(32'd16_777_216, 32'd16_777_216, 32'd759_250_125, 32'd759_250_125,
                    31'd4000, 31'd12000, 48'hFFFF_FE00_0000);
        add_random_cells(80, 256, 256, 60);
        drain();

        // extremes: saturation high, full-scale trig, zero inverse axis
        set_ellipse(32'd0, 32'd0, 32'hC000_0000, 32'h4000_0000,
                    31'd0, 31'd1000, 48'h7FFF_FFFF_FFFF);
        add_random_cells(30, 0, 0, 40);
        drain();
        set_ellipse(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    31'h7FFF_FFFF, 31'd0, 48'h8000_0000_0000);
        add_random_cells(20, 0, 0, 255);
        drain();
        set_ellipse(32'd33_554_432, 32'd0, 32'h4000_0000, 32'h0,
                    31'd2000, 31'd2000, 48'h8000_0000_0000);
        add_cell(511, 0);
        add_random_cells(30, 511, 0, 40);
        drain();

        // random ellipses
        for (int p = 0; p < 4; p++)
        begin
            logic [31:0] rc, rs;
            logic [47:0] rw;
            rc = $urandom_range(32'h8000_0000, 0) - 32'h4000_0000;
            rs = $urandom_range(32'h8000_0000, 0) - 32'h4000_0000;
            rw = rand48();
            if (p == 3)
            begin
                rc = $urandom;
                rs = $urandom;
            end
            set_ellipse($urandom_range(33_554_432, 0), $urandom_range(33_554_432, 0),
                        rc, rs, 31'($urandom_range(20000, 0)), 31'($urandom_range(20000, 0)),
                        (p == 3) ? rw : {{8{rw[47]}}, rw[47:8]});
            add_random_cells(55, ellipse.center_x >>> 16, ellipse.center_y >>> 16, 80);
            drain();
        end

        repeat (50) @(posedge clk);
        if (density_queue.size() > 0)
        begin
            $error("density_delta: %0d results never arrived", density_queue.size());
            errors++;
        end
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
